@@ design/scm_pkg.sv @@
// shared types and constants for the convergence monitor
// no dependencies
package scm_pkg;

  localparam int unsigned WIDE_W = 64;

  typedef enum logic [1:0] {
    CFG_RELATIVE_MODE    = 2'd0,
    CFG_INVERSE_TIMESTEP = 2'd1,
    CFG_TOLERANCE        = 2'd2,
    CFG_STEPS_NEEDED     = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_CONVERGED = 2'd1,
    ST_FAILED    = 2'd2
  } status_code_t;

  localparam logic        RESET_RELATIVE_MODE    = 1'b0;
  localparam logic [31:0] RESET_INVERSE_TIMESTEP = 32'd65536;
  localparam logic [31:0] RESET_TOLERANCE        = 32'd66;
  localparam logic [15:0] RESET_STEPS_NEEDED     = 16'd10;

  typedef struct packed {
    logic        relative_mode;
    logic [31:0] inverse_timestep;
    logic [31:0] tolerance;
    logic [15:0] steps_needed;
  } cfg_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] old_value;
    logic signed [WIDE_W-1:0] new_value;
    logic                     last_element;
    logic                     relative_mode;
  } qent_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL_LO,
    B_MUL_HI,
    B_RATE,
    B_RSQ,
    B_RACC,
    B_VSQ,
    B_VACC,
    B_CHK,
    B_SQRT_R,
    B_SQRT_V,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

@@ design/scm_in_if.sv @@
// input channel: element pair and last flag
// depends on nothing
interface scm_in_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] old_value;
  logic signed [VALUE_WIDTH-1:0] new_value;
  logic                          last_element;
  modport source (output valid, old_value, new_value, last_element, input ready);
  modport sink (input valid, old_value, new_value, last_element, output ready);
endinterface

@@ design/scm_out_if.sv @@
// result channel: norm, count and status per vector
// depends on nothing
interface scm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] error_norm;
  logic [15:0] steps_below;
  logic [1:0]  status;
  modport source (output valid, error_norm, steps_below, status, input ready);
  modport sink (input valid, error_norm, steps_below, status, output ready);
endinterface

@@ design/scm_front.sv @@
// front end: accepts items, sign-extends and tags them with the mode, two-entry queue
// depends on scm_pkg
module scm_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_old_value,
  input  logic signed [VALUE_WIDTH-1:0] in_new_value,
  input  logic                          in_last_element,
  input  logic                          relative_mode,
  output logic                          q_valid,
  output scm_pkg::qent_t                q_data,
  input  logic                          q_pop
);
  import scm_pkg::*;

  qent_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  qent_t       ent;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    ent.old_value     = {{(WIDE_W-VALUE_WIDTH){in_old_value[VALUE_WIDTH-1]}}, in_old_value};
    ent.new_value     = {{(WIDE_W-VALUE_WIDTH){in_new_value[VALUE_WIDTH-1]}}, in_new_value};
    ent.last_element  = in_last_element;
    ent.relative_mode = relative_mode;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ design/scm_back.sv @@
// back end: rate, squares, accumulation, square roots, division and vector result
// depends on scm_pkg
module scm_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  scm_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  scm_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_error_norm,
  output logic [15:0]    out_steps_below,
  output logic [1:0]     out_status
);
  import scm_pkg::*;

  localparam int DIVW = 32 + FRACTION_BITS;
  localparam int CW   = $clog2(DIVW + 1);

  back_state_t state_r, state_nxt;

  logic [63:0] d_r, c_r, lo_r, hi_r, prod_r, rsum_r, vsum_r;
  logic [31:0] rate_r, err_r;
  logic        last_r, mode_r, ovf_r;
  logic [63:0] sx_r, sres_r, sbit_r;
  logic [31:0] div_r, rem_r;
  logic [DIVW-1:0] dq_r;
  logic [CW-1:0]   cnt_r;
  logic [15:0]     below_r;

  logic        out_valid_r;
  logic [31:0] out_err_r;
  logic [15:0] out_steps_r;
  logic [1:0]  out_status_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic signed [63:0] dd;
  logic [63:0] rate_sum;
  logic        rate_ok;
  logic [63:0] acc_add, acc_base, acc_sum;
  logic        acc_ovf;
  logic [63:0] strial;
  logic [32:0] dtrial;
  logic        sqrt_done, div_done;
  logic [15:0] below_new;

  assign out_valid       = out_valid_r;
  assign out_error_norm  = out_err_r;
  assign out_steps_below = out_steps_r;
  assign out_status      = out_status_r;

  // outputs of the sequencer
  always_comb begin
    q_pop = (state_r == B_IDLE) && q_valid;
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      B_MUL_LO: begin
        mul_a = d_r[31:0];
        mul_b = cfg.inverse_timestep;
      end
      B_MUL_HI: begin
        mul_a = d_r[63:32];
        mul_b = cfg.inverse_timestep;
      end
      B_RSQ: begin
        mul_a = rate_r;
        mul_b = rate_r;
      end
      B_VSQ: begin
        mul_a = c_r[31:0];
        mul_b = c_r[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign dd       = q_data.new_value - q_data.old_value;
  assign rate_sum = {hi_r[47:0], 16'd0} + {16'd0, lo_r[63:16]};
  assign rate_ok  = (hi_r[63:32] == 32'd0) && (rate_sum[63:32] == 32'd0);
  assign acc_base = (state_r == B_RACC) ? rsum_r : vsum_r;
  assign acc_add  = prod_r;
  assign acc_sum  = acc_base + acc_add;
  assign acc_ovf  = acc_base > (~acc_add);
  assign strial   = sres_r + sbit_r;
  assign dtrial   = {rem_r, dq_r[DIVW-1]};
  assign sqrt_done = (cnt_r == CW'(31));
  assign div_done  = (cnt_r == CW'(DIVW - 1));
  assign below_new = (err_r < cfg.tolerance) ?
                     ((below_r == 16'hFFFF) ? below_r : below_r + 16'd1) : 16'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (q_valid) state_nxt = B_MUL_LO;
      B_MUL_LO: state_nxt = B_MUL_HI;
      B_MUL_HI: state_nxt = B_RATE;
      B_RATE:   state_nxt = rate_ok ? B_RSQ : (mode_r ? B_VSQ : B_CHK);
      B_RSQ:    state_nxt = B_RACC;
      B_RACC:   state_nxt = mode_r ? B_VSQ : B_CHK;
      B_VSQ:    state_nxt = (c_r[63:32] != 32'd0) ? B_CHK : B_VACC;
      B_VACC:   state_nxt = B_CHK;
      B_CHK: begin
        priority if (!last_r) state_nxt = B_IDLE;
        else if (ovf_r)       state_nxt = B_FIN;
        else                  state_nxt = B_SQRT_R;
      end
      B_SQRT_R: if (sqrt_done) state_nxt = mode_r ? B_SQRT_V : B_FIN;
      B_SQRT_V: if (sqrt_done) state_nxt = B_DIV;
      B_DIV:    if (div_done) state_nxt = B_FIN;
      B_FIN:    if (!out_valid_r) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      rsum_r      <= '0;
      vsum_r      <= '0;
      ovf_r       <= 1'b0;
      below_r     <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            d_r    <= dd[63] ? -dd : dd;
            c_r    <= q_data.new_value[63] ? -q_data.new_value : q_data.new_value;
            last_r <= q_data.last_element;
            mode_r <= q_data.relative_mode;
          end
        end
        B_MUL_LO: lo_r <= mul_p;
        B_MUL_HI: hi_r <= mul_p;
        B_RATE: begin
          rate_r <= rate_sum[31:0];
          if (!rate_ok) begin
            rsum_r <= '1;
            ovf_r  <= 1'b1;
          end
        end
        B_RSQ: prod_r <= mul_p;
        B_RACC: begin
          rsum_r <= acc_ovf ? '1 : acc_sum;
          if (acc_ovf) ovf_r <= 1'b1;
        end
        B_VSQ: begin
          prod_r <= mul_p;
          if (c_r[63:32] != 32'd0) begin
            vsum_r <= '1;
            ovf_r  <= 1'b1;
          end
        end
        B_VACC: begin
          vsum_r <= acc_ovf ? '1 : acc_sum;
          if (acc_ovf) ovf_r <= 1'b1;
        end
        B_CHK: begin
          sx_r   <= rsum_r;
          sres_r <= '0;
          sbit_r <= 64'h4000_0000_0000_0000;
          cnt_r  <= '0;
        end
        B_SQRT_R, B_SQRT_V: begin
          if (sqrt_done) begin
            cnt_r  <= '0;
            sx_r   <= vsum_r;
            sbit_r <= 64'h4000_0000_0000_0000;
            sres_r <= '0;
            if (state_r == B_SQRT_R) begin
              err_r <= (sx_r >= strial) ? 32'(((sres_r >> 1) + sbit_r)) : 32'(sres_r >> 1);
            end else begin
              rem_r <= 32'd0;
              dq_r  <= {err_r, {FRACTION_BITS{1'b0}}};
              if (sx_r >= strial) begin
                div_r <= 32'(((sres_r >> 1) + sbit_r));
              end else begin
                div_r <= ((sres_r >> 1) == 64'd0) ? 32'd1 : 32'(sres_r >> 1);
              end
            end
          end else begin
            if (sx_r >= strial) begin
              sx_r   <= sx_r - strial;
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
            cnt_r  <= cnt_r + CW'(1);
          end
        end
        B_DIV: begin
          if (dtrial >= {1'b0, div_r}) begin
            rem_r <= 32'(dtrial - {1'b0, div_r});
            dq_r  <= {dq_r[DIVW-2:0], 1'b1};
          end else begin
            rem_r <= dtrial[31:0];
            dq_r  <= {dq_r[DIVW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CW'(1);
          if (div_done) begin
            mode_r <= 1'b0;
            err_r  <= (dq_r[DIVW-2:31] != '0) ? 32'hFFFF_FFFF :
                      {dq_r[30:0], (dtrial >= {1'b0, div_r})};
          end
        end
        B_FIN: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            if (ovf_r) begin
              out_err_r    <= 32'hFFFF_FFFF;
              out_steps_r  <= below_r;
              out_status_r <= ST_FAILED;
            end else begin
              out_err_r    <= err_r;
              out_steps_r  <= below_new;
              below_r      <= below_new;
              out_status_r <= (below_new >= cfg.steps_needed) ? ST_CONVERGED : ST_RUNNING;
            end
            rsum_r <= '0;
            vsum_r <= '0;
            ovf_r  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

@@ design/steady_state_convergence_monitor.sv @@
// convergence monitor top: config registers, front queue and back sequencer
// depends on scm_pkg, scm_in_if, scm_out_if, scm_front, scm_back
// the back end finishes each item before it takes the next; items pass the shared
// 32x32 multiplier, the last item of a vector without overflow adds 32-step square roots
// (the second one, and the divider, in relative mode only), and a result waits while the
// previous result is unread; synchronous active-low reset
module steady_state_convergence_monitor #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  scm_in_if.sink      in_ch,
  scm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import scm_pkg::*;

  cfg_t           cfg_r;
  logic           q_valid, q_pop;
  qent_t          q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relative_mode    <= RESET_RELATIVE_MODE;
      cfg_r.inverse_timestep <= RESET_INVERSE_TIMESTEP;
      cfg_r.tolerance        <= RESET_TOLERANCE;
      cfg_r.steps_needed     <= RESET_STEPS_NEEDED;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RELATIVE_MODE:    cfg_r.relative_mode    <= cfg_data[0];
        CFG_INVERSE_TIMESTEP: cfg_r.inverse_timestep <= cfg_data;
        CFG_TOLERANCE:        cfg_r.tolerance        <= cfg_data;
        CFG_STEPS_NEEDED:     cfg_r.steps_needed     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  scm_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_old_value    (in_ch.old_value),
    .in_new_value    (in_ch.new_value),
    .in_last_element (in_ch.last_element),
    .relative_mode   (cfg_r.relative_mode),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop)
  );

  scm_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_error_norm  (out_ch.error_norm),
    .out_steps_below (out_ch.steps_below),
    .out_status      (out_ch.status)
  );

`ifndef SYNTHESIS
  a_fail_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FAILED) |-> out_ch.error_norm == 32'hFFFF_FFFF)
    else $error("failed vector without saturated norm");
  a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_CONVERGED) |->
    out_ch.steps_below >= cfg_r.steps_needed)
    else $error("converged with count below limit");
  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_RUNNING) |->
    out_ch.steps_below < cfg_r.steps_needed)
    else $error("running with count at limit");
`endif
endmodule

@@ verif/tb_scm_channels.sv @@
`timescale 1ns / 1ps
// no testbench-side channel definitions are needed: the design interfaces are reused
// depends on nothing; the bench uses design/scm_in_if.sv and design/scm_out_if.sv
package tb_scm_channels_pkg;
  localparam int unsigned DRAIN_CYCLES = 200;
endpackage

@@ verif/tb_steady_state_convergence_monitor.sv @@
`timescale 1ns / 1ps
// self-checking bench for the convergence monitor: directed rows, then random vectors
// predicts norms, counts and status in-bench; depends on scm_pkg, tb_scm_channels_pkg and the channel interfaces
module tb_steady_state_convergence_monitor;
  import scm_pkg::*;
  import tb_scm_channels_pkg::*;

  typedef struct {
    logic [31:0] norm;
    logic [15:0] count;
    status_code_t st;
  } verdict_t;

  typedef struct {
    logic [31:0] old_v;
    logic [31:0] new_v;
    logic        last;
    logic        has_fixed;
    logic [31:0] fixed_norm;
    status_code_t fixed_st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_RELATIVE_MODE;
  logic [31:0] cfg_data = '0;

  scm_in_if #(.VALUE_WIDTH(32)) in_ch ();
  scm_out_if out_ch ();

  steady_state_convergence_monitor u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic        m_rel;
  logic [31:0] m_inv_dt;
  logic [31:0] m_tol;
  logic [15:0] m_need;
  logic [63:0] m_rate_sq;
  logic [63:0] m_val_sq;
  logic        m_ovf;
  logic [15:0] m_count;

  verdict_t norm_queue[$];
  int errors = 0;
  int vectors_seen = 0;
  int items_sent = 0;
  longint cycles = 0;
  bit stall_out = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (vector %0d)", what, got, want, vectors_seen);
    errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void add_sat(ref logic [63:0] s, input logic [63:0] a);
    if (s > 64'hFFFF_FFFF_FFFF_FFFF - a) begin
      s = '1;
      m_ovf = 1'b1;
    end else begin
      s = s + a;
    end
  endfunction

  function automatic bit predict_norm(input logic [31:0] ov, input logic [31:0] nv,
                                      input logic last, output verdict_t v);
    logic signed [33:0] diff;
    logic [33:0] d;
    logic [65:0] prod;
    logic [63:0] rate;
    logic [32:0] c;
    logic [63:0] e;
    logic [63:0] cn;
    diff = $signed({{2{nv[31]}}, nv}) - $signed({{2{ov[31]}}, ov});
    d = diff[33] ? -diff : diff;
    prod = d * m_inv_dt;
    if (prod[65:48] != 0) begin
      m_rate_sq = '1;
      m_ovf = 1'b1;
    end else begin
      rate = prod[47:16];
      add_sat(m_rate_sq, rate * rate);
    end
    if (m_rel) begin
      c = nv[31] ? -{1'b1, nv} : {1'b0, nv};
      add_sat(m_val_sq, c * c);
    end
    if (!last) return 0;
    if (m_ovf) begin
      v.norm = '1;
      v.st = ST_FAILED;
    end else begin
      e = isqrt(m_rate_sq);
      if (m_rel) begin
        cn = isqrt(m_val_sq);
        if (cn == 0) cn = 1;
        e = (e << 16) / cn;
        if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      end
      v.norm = e[31:0];
      if (e < m_tol) begin
        if (m_count != 16'hFFFF) m_count++;
      end else begin
        m_count = 0;
      end
      v.st = (m_count >= m_need) ? ST_CONVERGED : ST_RUNNING;
    end
    v.count = m_count;
    m_rate_sq = 0;
    m_val_sq = 0;
    m_ovf = 0;
    return 1;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_steady_state_convergence_monitor failed");
      $finish;
    end
  end

  // receiver: once stall_out is set, stalls on a rotating pattern and at random
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (stall_out) out_ch.ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (norm_queue.size() == 0) begin
        $display("unexpected result with nothing pending");
        errors++;
      end else begin
        verdict_t w;
        w = norm_queue.pop_front();
        if (out_ch.error_norm !== w.norm) report("error_norm", out_ch.error_norm, w.norm);
        if (out_ch.steps_below !== w.count)
          report("steps_below", 32'(out_ch.steps_below), 32'(w.count));
        if (out_ch.status !== w.st) report("status", 32'(out_ch.status), 32'(w.st));
      end
      vectors_seen++;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RELATIVE_MODE:    m_rel = val[0];
      CFG_INVERSE_TIMESTEP: m_inv_dt = val;
      CFG_TOLERANCE:        m_tol = val;
      default:              m_need = val[15:0];
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sends one item and, if it ends a vector, queues its expectation; gap is idle cycles before it
  task automatic send_item(input logic [31:0] ov, input logic [31:0] nv, input logic last,
                           input int gap, input row_t r);
    verdict_t v;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.old_value <= ov;
    in_ch.new_value <= nv;
    in_ch.last_element <= last;
    if (predict_norm(ov, nv, last, v)) begin
      if (r.has_fixed) begin
        if (v.norm !== r.fixed_norm || v.st !== r.fixed_st) begin
          $display("directed row disagrees with prediction");
          errors++;
        end
      end
      norm_queue.insert(norm_queue.size(), v);
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [31:0] rnd_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  row_t dir_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'd0, ST_RUNNING},
    '{32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1, 32'd0, ST_RUNNING},
    '{32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, ST_RUNNING},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_RUNNING},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_RUNNING},
    '{32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 32'd0, ST_RUNNING},
    '{32'h0000_0000, 32'h0000_0004, 1'b1, 1'b0, 32'd0, ST_RUNNING},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 32'd0, ST_RUNNING},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'd0, ST_RUNNING},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0, ST_RUNNING}
  };

  initial begin
    row_t none;
    int burst;
    int kind;
    int vlen;
    logic [31:0] base;
    logic [31:0] ov;
    logic [31:0] nv;
    in_ch.valid = 1'b0;
    in_ch.old_value = '0;
    in_ch.new_value = '0;
    in_ch.last_element = 1'b0;
    none = '{0, 0, 0, 0, 0, ST_RUNNING};
    m_rel = RESET_RELATIVE_MODE;
    m_inv_dt = RESET_INVERSE_TIMESTEP;
    m_tol = RESET_TOLERANCE;
    m_need = RESET_STEPS_NEEDED;
    m_rate_sq = 0;
    m_val_sq = 0;
    m_ovf = 0;
    m_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings first, then extreme values of the registers
    foreach (dir_rows[i]) send_item(dir_rows[i].old_v, dir_rows[i].new_v, dir_rows[i].last,
                                    0, dir_rows[i]);
    wait_idle();
    write_reg(CFG_RELATIVE_MODE, 32'd1);
    write_reg(CFG_INVERSE_TIMESTEP, 32'd0);
    write_reg(CFG_STEPS_NEEDED, 32'd0);
    send_item(32'h1234_5678, 32'h0000_0000, 1'b1, 0, none);
    send_item(32'h8000_0000, 32'h8000_0000, 1'b1, 0, none);
    send_item(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 0, none);
    wait_idle();
    write_reg(CFG_INVERSE_TIMESTEP, 32'hFFFF_FFFF);
    write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
    write_reg(CFG_STEPS_NEEDED, 32'hFFFF);
    send_item(32'h0000_0000, 32'h0000_0001, 1'b1, 0, none);
    send_item(32'h0000_0000, 32'h0001_0000, 1'b1, 0, none);
    send_item(32'h0000_0010, 32'h0000_0000, 1'b1, 0, none);
    wait_idle();

    // random phases over several register settings
    stall_out = 1;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_RELATIVE_MODE, $urandom_range(0, 1));
      case (ph % 4)
        0: write_reg(CFG_INVERSE_TIMESTEP, 32'h0001_0000);
        1: write_reg(CFG_INVERSE_TIMESTEP, $urandom);
        2: write_reg(CFG_INVERSE_TIMESTEP, $urandom_range(0, 32'h0010_0000));
        default: write_reg(CFG_INVERSE_TIMESTEP, 32'd0);
      endcase
      write_reg(CFG_TOLERANCE, (ph == 7) ? 32'd0 : $urandom_range(0, 32'h0004_0000));
      write_reg(CFG_STEPS_NEEDED, (ph == 6) ? 32'd1 : $urandom_range(1, 6));
      burst = 0;
      for (int n = 0; n < 200; ) begin
        kind = $urandom_range(0, 9);
        vlen = $urandom_range(1, 6);
        base = rnd_value(kind < 2 ? 0 : 1);
        for (int e = 0; e < vlen; e++) begin
          ov = (kind < 2) ? rnd_value(0) : base + rnd_value(1);
          nv = (kind < 2) ? rnd_value(0) : ov + rnd_value(2) - 32'd128;
          if (burst == 0) burst = $urandom_range(1, 12);
          send_item(ov, nv, e == vlen - 1,
                    (burst == 1 && ph % 2 == 1) ? $urandom_range(1, 6) : 0, none);
          burst--;
          n++;
        end
      end
      wait_idle();
    end

    $display("covered %0d items, %0d vectors, absolute and relative norms over 8 settings",
             items_sent, vectors_seen);
    if (errors == 0) begin
      $display("tb_steady_state_convergence_monitor passed");
    end else begin
      $display("tb_steady_state_convergence_monitor failed");
    end
    $finish;
  end
endmodule

@@ steady_state_convergence_monitor.f @@
design/scm_pkg.sv
design/scm_in_if.sv
design/scm_out_if.sv
design/scm_front.sv
design/scm_back.sv
design/steady_state_convergence_monitor.sv
verif/tb_scm_channels.sv
verif/tb_steady_state_convergence_monitor.sv
